// ----- sv/bblc_pkg.sv -----
package bblc_pkg;

	// Request codes carried in the input item.
	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_TRIM   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	// Configuration register indexes.
	localparam logic [0:0] REG_ENABLE = 1'b0;
	localparam logic [0:0] REG_BUDGET = 1'b1;

	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	typedef struct packed {
		req_t        req_type;
		logic [63:0] id_high;
		logic [63:0] id_low;
		logic [1:0]  detail_level;
		logic [47:0] entry_size;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] hit_size;
		logic        accepted;
		logic [6:0]  evicted_now;
		logic [6:0]  entry_count;
		logic [47:0] bytes_held;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] insert_total;
		logic [31:0] eviction_total;
		logic [47:0] served_bytes_total;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_APPLY,
		ST_EVRD,
		ST_EVICT,
		ST_PLACE,
		ST_TRIM,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear;
		logic scan;
		logic apply;
		logic evict_rd;
		logic evict;
		logic place;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		req_t req;
		logic enable;
		logic admit;
		logic scan_done;
		logic found;
		logic full;
		logic over;
	} status_t;

endpackage

// ----- sv/bblc_ctrl.sv -----
module bblc_ctrl import bblc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   place_pend_q, place_pend_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			place_pend_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			place_pend_q <= place_pend_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		place_pend_d = place_pend_q;
		cmd          = '0;
		in_stall     = 1'b1;
		out_valid    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (status.req)
					REQ_LOOKUP: state_d = status.enable ? ST_SCAN : ST_OUT;
					REQ_INSERT: state_d = status.admit ? ST_SCAN : ST_OUT;
					REQ_TRIM:   state_d = ST_TRIM;
					REQ_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ST_OUT;
					end
					default:    state_d = ST_OUT;
				endcase
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				if (status.req != REQ_INSERT) begin
					state_d = ST_OUT;
				end else if (status.found) begin
					state_d = ST_TRIM;
				end else if (status.full) begin
					place_pend_d = 1'b1;
					state_d      = ST_EVRD;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_EVRD: begin
				cmd.evict_rd = 1'b1;
				state_d      = ST_EVICT;
			end
			ST_EVICT: begin
				cmd.evict    = 1'b1;
				place_pend_d = 1'b0;
				state_d      = place_pend_q ? ST_PLACE : ST_TRIM;
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = ST_TRIM;
			end
			ST_TRIM: begin
				state_d = status.over ? ST_EVRD : ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- sv/bblc_dp.sv -----
module bblc_dp import bblc_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_item,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  cmd_t        cmd,
	output status_t     status,
	output out_item_t   out_item
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int KW = 130;

	in_item_t    req_q;
	logic        enable_q;
	logic [47:0] budget_q;

	logic [ENTRIES-1:0] valid_q;
	logic [AW-1:0]      age_q [ENTRIES];
	logic [CW-1:0]      count_q;
	// One bit of headroom: an insert may briefly push the total past 48 bits.
	logic [48:0]        held_q;
	logic [31:0]        hits_q, misses_q, inserts_q, evictions_q;
	logic [47:0]        served_q;

	logic [CW-1:0] scan_cnt_q;
	logic          cmp_vld_s1;
	logic [AW-1:0] cmp_idx_s1;
	logic          found_q, free_seen_q;
	logic [AW-1:0] found_idx_q, free_idx_q, evict_idx_q;
	logic [47:0]   hit_size_q;
	logic          hit_q, accepted_q;
	logic [6:0]    evn_q;

	logic [KW-1:0] key_mem [ENTRIES];
	logic [47:0]   size_mem [ENTRIES];
	logic [KW-1:0] key_rd_q;
	logic [47:0]   size_rd_q;

	logic [AW-1:0] scan_addr, size_raddr, victim, place_idx, size_waddr;
	logic [AW-1:0] sel_age, oldest;
	logic          size_we;
	logic [47:0]   size_wdata;
	logic [KW-1:0] req_key;
	logic          key_match;
	logic [48:0]   served_sum;

	assign req_key    = {req_q.id_high, req_q.id_low, req_q.detail_level};
	assign scan_addr  = scan_cnt_q[AW-1:0];
	assign oldest     = AW'(count_q - CW'(1));
	assign place_idx  = free_seen_q ? free_idx_q : evict_idx_q;
	assign size_raddr = cmd.evict_rd ? victim : scan_addr;
	assign key_match  = valid_q[cmp_idx_s1] && (key_rd_q == req_key);
	assign served_sum = {1'b0, served_q} + {1'b0, hit_size_q};

	// Age of the found slot and the least recent valid slot.
	always_comb begin
		sel_age = '0;
		victim  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (found_idx_q == AW'(i)) begin
				sel_age = sel_age | age_q[i];
			end
			if (valid_q[i] && (age_q[i] == oldest)) begin
				victim = victim | AW'(i);
			end
		end
	end

	// Size memory write selection.
	always_comb begin
		size_we    = 1'b0;
		size_waddr = found_idx_q;
		size_wdata = req_q.entry_size;
		if (cmd.apply && req_q.req_type == REQ_INSERT && found_q) begin
			size_we = 1'b1;
		end else if (cmd.place) begin
			size_we    = 1'b1;
			size_waddr = place_idx;
		end
	end

	// Key and size memories with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			key_mem[place_idx] <= req_key;
		end
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		key_rd_q  <= key_mem[scan_addr];
		size_rd_q <= size_mem[size_raddr];
	end

	// Captured request and scan results.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_item;
		end
		if (cmd.scan && cmp_vld_s1 && key_match && !found_q) begin
			found_idx_q <= cmp_idx_s1;
			hit_size_q  <= size_rd_q;
		end
		if (cmd.scan && cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_seen_q) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (cmd.evict) begin
			evict_idx_q <= victim;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			budget_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_BUDGET: budget_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Scan sequencing, recency ranks, totals and per-item results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			found_q     <= 1'b0;
			free_seen_q <= 1'b0;
			valid_q     <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
			count_q     <= '0;
			held_q      <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			inserts_q   <= '0;
			evictions_q <= '0;
			served_q    <= '0;
			hit_q       <= 1'b0;
			accepted_q  <= 1'b0;
			evn_q       <= '0;
		end else begin
			if (cmd.load) begin
				scan_cnt_q  <= '0;
				cmp_vld_s1  <= 1'b0;
				found_q     <= 1'b0;
				free_seen_q <= 1'b0;
				hit_q       <= 1'b0;
				accepted_q  <= 1'b0;
				evn_q       <= '0;
			end
			if (cmd.clear) begin
				valid_q <= '0;
				count_q <= '0;
				held_q  <= '0;
			end
			// One slot issued per cycle; compared in the cycle after.
			if (cmd.scan) begin
				cmp_vld_s1 <= (scan_cnt_q != CW'(ENTRIES));
				cmp_idx_s1 <= scan_addr;
				if (scan_cnt_q != CW'(ENTRIES)) begin
					scan_cnt_q <= scan_cnt_q + CW'(1);
				end
				if (cmp_vld_s1 && key_match) begin
					found_q <= 1'b1;
				end
				if (cmp_vld_s1 && !valid_q[cmp_idx_s1]) begin
					free_seen_q <= 1'b1;
				end
			end
			if (cmd.apply) begin
				if (req_q.req_type == REQ_LOOKUP) begin
					if (found_q) begin
						hit_q    <= 1'b1;
						hits_q   <= (hits_q == MAX32) ? MAX32 : hits_q + 32'd1;
						served_q <= (served_sum >= {1'b0, MAX48}) ? MAX48 : served_sum[47:0];
					end else begin
						misses_q <= (misses_q == MAX32) ? MAX32 : misses_q + 32'd1;
					end
				end else if (found_q) begin
					held_q     <= held_q - {1'b0, hit_size_q} + {1'b0, req_q.entry_size};
					accepted_q <= 1'b1;
					inserts_q  <= (inserts_q == MAX32) ? MAX32 : inserts_q + 32'd1;
				end
				// Found slot becomes most recent; younger ones age by one.
				if (found_q) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (found_idx_q == AW'(i)) begin
							age_q[i] <= '0;
						end else if (valid_q[i] && age_q[i] < sel_age) begin
							age_q[i] <= age_q[i] + AW'(1);
						end
					end
				end
			end
			// Drop the least recent entry.
			if (cmd.evict) begin
				valid_q[victim] <= 1'b0;
				count_q         <= count_q - CW'(1);
				held_q          <= held_q - {1'b0, size_rd_q};
				evn_q           <= evn_q + 7'd1;
				evictions_q     <= (evictions_q == MAX32) ? MAX32 : evictions_q + 32'd1;
			end
			// New entry enters as most recent.
			if (cmd.place) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (place_idx == AW'(i)) begin
						age_q[i] <= '0;
					end else if (valid_q[i]) begin
						age_q[i] <= age_q[i] + AW'(1);
					end
				end
				valid_q[place_idx] <= 1'b1;
				count_q            <= count_q + CW'(1);
				held_q             <= held_q + {1'b0, req_q.entry_size};
				accepted_q         <= 1'b1;
				inserts_q          <= (inserts_q == MAX32) ? MAX32 : inserts_q + 32'd1;
			end
		end
	end

	// Status towards the controller.
	always_comb begin
		status.req       = req_q.req_type;
		status.enable    = enable_q;
		status.admit     = enable_q && (req_q.entry_size != '0) &&
		                   (req_q.entry_size <= budget_q);
		status.scan_done = (scan_cnt_q == CW'(ENTRIES)) && !cmp_vld_s1;
		status.found     = found_q;
		status.full      = (count_q == CW'(ENTRIES));
		status.over      = (held_q > {1'b0, budget_q}) && (count_q != '0);
	end

	// Result item, held steady while it waits.
	always_comb begin
		out_item.hit                = hit_q;
		out_item.hit_size           = hit_q ? hit_size_q : '0;
		out_item.accepted           = accepted_q;
		out_item.evicted_now        = evn_q;
		out_item.entry_count        = 7'(count_q);
		out_item.bytes_held         = held_q[47:0];
		out_item.hit_total          = hits_q;
		out_item.miss_total         = misses_q;
		out_item.insert_total       = inserts_q;
		out_item.eviction_total     = evictions_q;
		out_item.served_bytes_total = served_q;
	end

endmodule

// ----- sv/byte_budget_lru_cache_tags.sv -----
// Steps after an item is taken: the request is decoded; a lookup scans every slot,
// one per cycle, then records a hit or a miss; an insert scans, then updates a
// present key or places a new one, evicting the oldest first if the table is full.
// Inserts and trims then evict while over budget; clear and ignored items do not scan.
// One item is in work at a time; the next can be taken in the cycle after the result has gone.
// Reset (arst_n low) empties the table and zeroes all totals, settings and state flags.
module byte_budget_lru_cache_tags import bblc_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	bblc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Tag store, recency ranks and totals.
	bblc_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_item)
	);

endmodule

// ----- sv/bblc_checker.sv -----
module bblc_checker import bblc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// No result in the cycle right after an item is taken.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");

	// No new item while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("item taken while result pending");

	// Stored entries always have a nonzero size.
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.hit |-> out_item.hit_size != '0)
		else $error("hit with zero size");

	// A request cannot both hit and be stored.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.hit && out_item.accepted))
		else $error("hit and accepted together");

endmodule

bind byte_budget_lru_cache_tags bblc_checker u_bblc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import bblc_pkg::*;

	localparam int SLOTS = 64;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_ENABLE;
	logic [47:0] cfg_data = '0;

	byte_budget_lru_cache_tags i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted cache state and settings.
	logic        pool_on;
	logic [47:0] budget;
	logic        tag_valid [SLOTS];
	logic [63:0] tag_hi [SLOTS];
	logic [63:0] tag_lo [SLOTS];
	logic [1:0]  tag_det [SLOTS];
	logic [47:0] tag_size [SLOTS];
	int          tag_rank [SLOTS];
	// Wide enough that an insert can take the total past 48 bits before trimming.
	logic [63:0] held;
	logic [31:0] n_hits, n_misses, n_inserts, n_evictions;
	logic [47:0] n_served;

	out_item_t expected_results[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit stall_random = 1'b1;

	// A small pool of keys so that lookups and inserts collide often.
	logic [63:0] key_hi [8];
	logic [63:0] key_lo [8];

	function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? MAX32 : s[31:0];
	endfunction

	function automatic logic [47:0] add48(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? MAX48 : s[47:0];
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) if (tag_valid[i]) n++;
		return n;
	endfunction

	function automatic int drop_oldest();
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++)
			if (tag_valid[i] && (best < 0 || tag_rank[i] > tag_rank[best])) best = i;
		if (best < 0) return 0;
		held = held - 64'(tag_size[best]);
		tag_valid[best] = 1'b0;
		n_evictions = add32(n_evictions, 32'd1);
		return 1;
	endfunction

	function automatic int shrink_to_budget();
		int n;
		n = 0;
		while (held > 64'(budget)) begin
			if (drop_oldest() == 0) break;
			n++;
		end
		return n;
	endfunction

	function automatic void promote(int s);
		int a;
		a = tag_rank[s];
		for (int i = 0; i < SLOTS; i++)
			if (tag_valid[i] && i != s && tag_rank[i] < a) tag_rank[i]++;
		tag_rank[s] = 0;
	endfunction

	function automatic int lookup_slot(in_item_t it);
		for (int i = 0; i < SLOTS; i++)
			if (tag_valid[i] && tag_hi[i] == it.id_high && tag_lo[i] == it.id_low &&
			    tag_det[i] == it.detail_level) return i;
		return -1;
	endfunction

	// Work out the result of one request and update the predicted state.
	function automatic out_item_t cache_predict(in_item_t it);
		out_item_t r;
		int s, ev;
		r = '0;
		ev = 0;
		case (it.req_type)
			REQ_LOOKUP: begin
				if (pool_on) begin
					s = lookup_slot(it);
					if (s < 0) n_misses = add32(n_misses, 32'd1);
					else begin
						r.hit = 1'b1;
						r.hit_size = tag_size[s];
						promote(s);
						n_hits = add32(n_hits, 32'd1);
						n_served = add48(n_served, tag_size[s]);
					end
				end
			end
			REQ_INSERT: begin
				if (pool_on && it.entry_size != 0 && it.entry_size <= budget) begin
					s = lookup_slot(it);
					if (s >= 0) begin
						held = held - 64'(tag_size[s]);
						promote(s);
					end else begin
						if (live_count() >= SLOTS) ev += drop_oldest();
						for (int i = 0; i < SLOTS; i++)
							if (!tag_valid[i]) begin
								s = i;
								break;
							end
						for (int i = 0; i < SLOTS; i++) if (tag_valid[i]) tag_rank[i]++;
						tag_valid[s] = 1'b1;
						tag_hi[s] = it.id_high;
						tag_lo[s] = it.id_low;
						tag_det[s] = it.detail_level;
						tag_rank[s] = 0;
					end
					tag_size[s] = it.entry_size;
					held = held + 64'(it.entry_size);
					n_inserts = add32(n_inserts, 32'd1);
					r.accepted = 1'b1;
					ev += shrink_to_budget();
				end
			end
			REQ_TRIM: ev += shrink_to_budget();
			default: begin
				for (int i = 0; i < SLOTS; i++) tag_valid[i] = 1'b0;
				held = '0;
			end
		endcase
		r.evicted_now = ev[6:0];
		r.entry_count = 7'(live_count());
		r.bytes_held = held[47:0];
		r.hit_total = n_hits;
		r.miss_total = n_misses;
		r.insert_total = n_inserts;
		r.eviction_total = n_evictions;
		r.served_bytes_total = n_served;
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	// Offer one item and wait until the block takes it. The item stays offered
	// until the next one, a pause or a drain replaces it.
	task automatic send_request(in_item_t it);
		int g;
		g = gap_len();
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(cache_predict(it));
		n_sent++;
		@(negedge clk);
	endtask

	// Let every pending result arrive, then allow for the block's tail.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Registers are only written once nothing is in flight.
	task automatic write_reg(logic [0:0] idx, logic [47:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENABLE) pool_on = val[0];
		else budget = val;
	endtask

	function automatic in_item_t make_req(req_t t, int k, logic [1:0] d, logic [47:0] sz);
		in_item_t it;
		it.req_type = t;
		it.id_high = key_hi[k];
		it.id_low = key_lo[k];
		it.detail_level = d;
		it.entry_size = sz;
		return it;
	endfunction

	function automatic in_item_t random_req();
		in_item_t it;
		int p;
		p = $urandom_range(0, 99);
		it = make_req(REQ_LOOKUP, $urandom_range(0, 7), 2'($urandom_range(0, 3)),
			48'($urandom_range(1, 4000)));
		if (p < 45) it.req_type = REQ_LOOKUP;
		else if (p < 85) it.req_type = REQ_INSERT;
		else if (p < 95) it.req_type = REQ_TRIM;
		else if (p < 97) it.req_type = REQ_CLEAR;
		if ($urandom_range(0, 9) == 0) begin
			it.id_high = {$urandom, $urandom};
			it.id_low = {$urandom, $urandom};
			it.entry_size = 48'({$urandom, $urandom});
		end
		if ($urandom_range(0, 19) == 0) it.entry_size = '0;
		return it;
	endfunction

	task automatic test_directed();
		write_reg(REG_ENABLE, 48'd0);
		send_request(make_req(REQ_LOOKUP, 0, 2'd0, 48'd5));
		send_request(make_req(REQ_INSERT, 0, 2'd0, 48'd5));
		write_reg(REG_ENABLE, 48'd1);
		write_reg(REG_BUDGET, MAX48);
		send_request(make_req(REQ_INSERT, 0, 2'd3, 48'd0));
		send_request(make_req(REQ_INSERT, 0, 2'd3, MAX48));
		send_request(make_req(REQ_LOOKUP, 0, 2'd3, 48'd0));
		send_request(make_req(REQ_LOOKUP, 0, 2'd3, 48'd0));
		send_request(make_req(REQ_INSERT, 1, 2'd0, 48'd7));
		send_request(make_req(REQ_INSERT, 0, 2'd3, 48'd100));
		send_request(make_req(REQ_LOOKUP, 1, 2'd1, 48'd0));
		drain();
		write_reg(REG_BUDGET, 48'd50);
		send_request(make_req(REQ_TRIM, 0, 2'd0, 48'd0));
		send_request(make_req(REQ_INSERT, 2, 2'd2, 48'd51));
		send_request(make_req(REQ_INSERT, 2, 2'd2, 48'd50));
		send_request(make_req(REQ_INSERT, 3, 2'd2, 48'd20));
		send_request(make_req(REQ_CLEAR, 0, 2'd0, 48'd0));
		drain();
		write_reg(REG_ENABLE, 48'd0);
		send_request(make_req(REQ_TRIM, 0, 2'd0, 48'd0));
		send_request(make_req(REQ_CLEAR, 0, 2'd0, 48'd0));
		drain();
	endtask

	// Fill all slots with distinct keys, then push more to force table-full evictions.
	task automatic test_full_table();
		in_item_t it;
		write_reg(REG_ENABLE, 48'd1);
		write_reg(REG_BUDGET, MAX48);
		for (int i = 0; i < SLOTS + 6; i++) begin
			it = make_req(REQ_INSERT, i % 8, 2'(i / 8), 48'd3);
			it.id_low = it.id_low ^ 64'(i / 32);
			send_request(it);
		end
		send_request(make_req(REQ_LOOKUP, 7, 2'd3, 48'd0));
		drain();
	endtask

	// Receiver holds off while requests keep coming, so input stalls.
	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 6; i++) send_request(random_req());
		hold_off = 1'b0;
		drain();
	endtask

	task automatic test_random();
		logic [47:0] budgets [4];
		budgets = '{48'd0, 48'd3000, 48'd20000, MAX48};
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(REG_BUDGET, budgets[phase % 4]);
			write_reg(REG_ENABLE, 48'((phase % 4) != 3));
			stall_random = (phase != 2);
			for (int i = 0; i < 50; i++) send_request(random_req());
			drain();
		end
		stall_random = 1'b1;
	endtask

	// Receiver: random stalls, long hold-off on request.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				out_stall <= 1'b0;
				wait (!hold_off);
			end else if (stall_random && $urandom_range(0, 3) == 0) begin
				n = gap_len() + 1;
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (out_item.hit !== e.hit) begin
					$error("hit exp %0h got %0h", e.hit, out_item.hit); errors++; end
				if (out_item.hit_size !== e.hit_size) begin
					$error("hit_size exp %0h got %0h", e.hit_size, out_item.hit_size); errors++; end
				if (out_item.accepted !== e.accepted) begin
					$error("accepted exp %0h got %0h", e.accepted, out_item.accepted); errors++; end
				if (out_item.evicted_now !== e.evicted_now) begin
					$error("evicted_now exp %0d got %0d", e.evicted_now, out_item.evicted_now);
					errors++;
				end
				if (out_item.entry_count !== e.entry_count) begin
					$error("entry_count exp %0d got %0d", e.entry_count, out_item.entry_count);
					errors++;
				end
				if (out_item.bytes_held !== e.bytes_held) begin
					$error("bytes_held exp %0h got %0h", e.bytes_held, out_item.bytes_held);
					errors++;
				end
				if (out_item.hit_total !== e.hit_total) begin
					$error("hit_total exp %0h got %0h", e.hit_total, out_item.hit_total); errors++; end
				if (out_item.miss_total !== e.miss_total) begin
					$error("miss_total exp %0h got %0h", e.miss_total, out_item.miss_total);
					errors++;
				end
				if (out_item.insert_total !== e.insert_total) begin
					$error("insert_total exp %0h got %0h", e.insert_total, out_item.insert_total);
					errors++;
				end
				if (out_item.eviction_total !== e.eviction_total) begin
					$error("eviction_total exp %0h got %0h", e.eviction_total,
						out_item.eviction_total);
					errors++;
				end
				if (out_item.served_bytes_total !== e.served_bytes_total) begin
					$error("served_bytes_total exp %0h got %0h", e.served_bytes_total,
						out_item.served_bytes_total);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		pool_on = 1'b0;
		budget = '0;
		held = '0;
		n_hits = '0; n_misses = '0; n_inserts = '0; n_evictions = '0; n_served = '0;
		for (int i = 0; i < SLOTS; i++) begin
			tag_valid[i] = 1'b0; tag_hi[i] = '0; tag_lo[i] = '0;
			tag_det[i] = '0; tag_size[i] = '0; tag_rank[i] = 0;
		end
		key_hi[0] = '0;          key_lo[0] = '0;
		key_hi[1] = '1;          key_lo[1] = '1;
		key_hi[2] = '0;          key_lo[2] = '1;
		key_hi[3] = '1;          key_lo[3] = '0;
		for (int k = 4; k < 8; k++) begin
			key_hi[k] = {$urandom, $urandom};
			key_lo[k] = {$urandom, $urandom};
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random();
		drain();
		$display("Sent %0d requests and checked %0d results over all request kinds,",
			n_sent, n_checked);
		$display("including full-table, budget-trim and counter paths.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
